FILE: sv/lud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lud_pkg
// Types, constants and fixed-point helpers for the lens undistortion pipeline.
// ----------------------------------------------------------------------------
package lud_pkg;

    localparam int PT_W   = 24;
    localparam int WIDE_W = 32;
    localparam int STAGES_PER_ITER = 7;

    localparam logic [2:0] REG_FX_RECIP = 3'd0;
    localparam logic [2:0] REG_FY_RECIP = 3'd1;
    localparam logic [2:0] REG_CX       = 3'd2;
    localparam logic [2:0] REG_CY       = 3'd3;
    localparam logic [2:0] REG_LEFT_K   = 3'd4;
    localparam logic [2:0] REG_RIGHT_K  = 3'd5;

    localparam logic [31:0] FX_RECIP_RST = 32'd5151003;
    localparam logic [31:0] FY_RECIP_RST = 32'd5151003;
    localparam logic [15:0] CX_RST       = 16'd7680;
    localparam logic [15:0] CY_RST       = 16'd5760;

    typedef struct packed {
        logic signed [WIDE_W-1:0] v;
        logic                     s;
    } t_wide;

    typedef struct packed {
        logic signed [PT_W-1:0] v;
        logic                   s;
    } t_pt;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] xd;
        logic signed [PT_W-1:0] yd;
        logic [63:0]            k;
        logic                   s;
    } t_item;

    // Round to nearest, ties toward plus infinity.
    function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int n);
        return (p + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic t_wide sat32(input logic signed [63:0] v);
        t_wide r;
        if (v > 64'sd2147483647) begin
            r.v = 32'sh7FFFFFFF;
            r.s = 1'b1;
        end else if (v < -64'sd2147483648) begin
            r.v = 32'sh80000000;
            r.s = 1'b1;
        end else begin
            r.v = v[31:0];
            r.s = 1'b0;
        end
        return r;
    endfunction

    function automatic t_pt sat24(input logic signed [63:0] v);
        t_pt r;
        if (v > 64'sd8388607) begin
            r.v = 24'sh7FFFFF;
            r.s = 1'b1;
        end else if (v < -64'sd8388608) begin
            r.v = 24'sh800000;
            r.s = 1'b1;
        end else begin
            r.v = v[23:0];
            r.s = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] coef(input logic [63:0] k, input int idx);
        return $signed(k[16*idx +: 16]);
    endfunction

endpackage

FILE: sv/lud_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lud_norm
// Normalisation stage: centers the pixel and scales it by the focal reciprocal.
// ----------------------------------------------------------------------------
module lud_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [15:0]      i_u,
    input  logic [15:0]      i_v,
    input  logic             i_left,
    input  logic [31:0]      i_fx_recip,
    input  logic [31:0]      i_fy_recip,
    input  logic [15:0]      i_cx,
    input  logic [15:0]      i_cy,
    input  logic [63:0]      i_left_k,
    input  logic [63:0]      i_right_k,
    output logic             o_valid,
    output lud_pkg::t_item   o_item
);
    import lud_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    t_pt   xd;
    t_pt   yd;

    always_comb begin
        xd = sat24(rnd((64'($signed({1'b0, i_u})) - 64'($signed({1'b0, i_cx})))
                       * 64'($signed({1'b0, i_fx_recip})), 16));
        yd = sat24(rnd((64'($signed({1'b0, i_v})) - 64'($signed({1'b0, i_cy})))
                       * 64'($signed({1'b0, i_fy_recip})), 16));
        n_item.x  = xd.v;
        n_item.y  = yd.v;
        n_item.xd = xd.v;
        n_item.yd = yd.v;
        n_item.k  = i_left ? i_left_k : i_right_k;
        n_item.s  = xd.s | yd.s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/lud_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lud_iter
// One refinement step of the radial-tangential model in seven register stages.
// ----------------------------------------------------------------------------
module lud_iter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  lud_pkg::t_item   i_item,
    output logic             o_valid,
    output lud_pkg::t_item   o_item
);
    import lud_pkg::*;

    logic [STAGES_PER_ITER-1:0] r_v;

    t_item r1_it, r2_it, r3_it, r4_it, r5_it, r6_it, r7_it;
    t_item n1_it, n2_it, n3_it, n4_it, n5_it, n6_it, n7_it;

    t_wide r1_x2, r1_y2, r1_xy, n1_x2, n1_y2, n1_xy;
    t_wide r2_x2, r2_y2, r2_r2, r2_px, r2_py, n2_r2, n2_px, n2_py;
    t_wide r3_r4, r3_k1r2, r3_sx, r3_sy, r3_px, r3_py;
    t_wide n3_r4, n3_k1r2, n3_sx, n3_sy;
    t_wide r4_k2r4, r4_tpx, r4_tpy, r4_k1r2, r4_px, r4_py;
    t_wide n4_k2r4, n4_tpx, n4_tpy;
    t_wide r5_rad, r5_px, r5_py, r5_tpx, r5_tpy, n5_rad;
    t_wide r6_tx, r6_ty, r6_px, r6_py, r6_tpx, r6_tpy, n6_tx, n6_ty;
    t_wide ax, bx, ay, by;
    t_pt   nx, ny;

    always_comb begin
        n1_it = i_item;
        n1_x2 = sat32(rnd(64'(i_item.x) * 64'(i_item.x), 20));
        n1_y2 = sat32(rnd(64'(i_item.y) * 64'(i_item.y), 20));
        n1_xy = sat32(rnd(64'(i_item.x) * 64'(i_item.y), 20));
        n1_it.s = i_item.s | n1_x2.s | n1_y2.s | n1_xy.s;

        n2_it = r1_it;
        n2_r2 = sat32(64'(r1_x2.v) + 64'(r1_y2.v));
        n2_px = sat32(rnd((64'(coef(r1_it.k, 2)) * 64'(r1_xy.v)) <<< 1, 12));
        n2_py = sat32(rnd((64'(coef(r1_it.k, 3)) * 64'(r1_xy.v)) <<< 1, 12));
        n2_it.s = r1_it.s | n2_r2.s | n2_px.s | n2_py.s;

        n3_it   = r2_it;
        n3_r4   = sat32(rnd(64'(r2_r2.v) * 64'(r2_r2.v), 20));
        n3_k1r2 = sat32(rnd(64'(coef(r2_it.k, 0)) * 64'(r2_r2.v), 12));
        n3_sx   = sat32(64'(r2_r2.v) + (64'(r2_x2.v) <<< 1));
        n3_sy   = sat32(64'(r2_r2.v) + (64'(r2_y2.v) <<< 1));
        n3_it.s = r2_it.s | n3_r4.s | n3_k1r2.s | n3_sx.s | n3_sy.s;

        n4_it   = r3_it;
        n4_k2r4 = sat32(rnd(64'(coef(r3_it.k, 1)) * 64'(r3_r4.v), 12));
        n4_tpx  = sat32(rnd(64'(coef(r3_it.k, 3)) * 64'(r3_sx.v), 12));
        n4_tpy  = sat32(rnd(64'(coef(r3_it.k, 2)) * 64'(r3_sy.v), 12));
        n4_it.s = r3_it.s | n4_k2r4.s | n4_tpx.s | n4_tpy.s;

        n5_it   = r4_it;
        n5_rad  = sat32(64'(r4_k1r2.v) + 64'(r4_k2r4.v));
        n5_it.s = r4_it.s | n5_rad.s;

        n6_it   = r5_it;
        n6_tx   = sat32(rnd(64'(r5_it.x) * 64'(r5_rad.v), 20));
        n6_ty   = sat32(rnd(64'(r5_it.y) * 64'(r5_rad.v), 20));
        n6_it.s = r5_it.s | n6_tx.s | n6_ty.s;

        ax = sat32(64'(r6_tx.v) + 64'(r6_px.v));
        bx = sat32(64'(ax.v) + 64'(r6_tpx.v));
        ay = sat32(64'(r6_ty.v) + 64'(r6_py.v));
        by = sat32(64'(ay.v) + 64'(r6_tpy.v));
        nx = sat24(64'(r6_it.xd) - 64'(bx.v));
        ny = sat24(64'(r6_it.yd) - 64'(by.v));
        n7_it   = r6_it;
        n7_it.x = nx.v;
        n7_it.y = ny.v;
        n7_it.s = r6_it.s | ax.s | bx.s | ay.s | by.s | nx.s | ny.s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STAGES_PER_ITER-2:0], i_valid};
        end
        if (i_en) begin
            r1_it <= n1_it; r1_x2 <= n1_x2; r1_y2 <= n1_y2; r1_xy <= n1_xy;
            r2_it <= n2_it; r2_x2 <= r1_x2; r2_y2 <= r1_y2; r2_r2 <= n2_r2;
            r2_px <= n2_px; r2_py <= n2_py;
            r3_it <= n3_it; r3_r4 <= n3_r4; r3_k1r2 <= n3_k1r2;
            r3_sx <= n3_sx; r3_sy <= n3_sy; r3_px <= r2_px; r3_py <= r2_py;
            r4_it <= n4_it; r4_k2r4 <= n4_k2r4; r4_tpx <= n4_tpx; r4_tpy <= n4_tpy;
            r4_k1r2 <= r3_k1r2; r4_px <= r3_px; r4_py <= r3_py;
            r5_it <= n5_it; r5_rad <= n5_rad; r5_px <= r4_px; r5_py <= r4_py;
            r5_tpx <= r4_tpx; r5_tpy <= r4_tpy;
            r6_it <= n6_it; r6_tx <= n6_tx; r6_ty <= n6_ty; r6_px <= r5_px;
            r6_py <= r5_py; r6_tpx <= r5_tpx; r6_tpy <= r5_tpy;
            r7_it <= n7_it;
        end
    end

    assign o_valid = r_v[STAGES_PER_ITER-1];
    assign o_item  = r7_it;

endmodule

FILE: sv/iterative_lens_undistortion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_lens_undistortion_unit
// Pixel to normalised ray with fixed-iteration radial-tangential undistortion.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  in      | i_in_valid / o_in_ready    | i_pixel_u, i_pixel_v, i_camera_left
//  out     | o_out_valid / i_out_ready  | o_ray_x, o_ray_y, o_saturated
//  config  | psel, penable, pwrite      | paddr, pwdata, prdata
//
// One beat enters per cycle while the output side is not stalled; the pipeline
// is one normalise stage plus seven register stages per unrolled iteration.
// A stalled output beat freezes the whole pipeline; nothing is dropped.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module iterative_lens_undistortion_unit #(
    parameter int ITERATIONS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_pixel_u,
    input  logic [15:0]        i_pixel_v,
    input  logic               i_camera_left,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_ray_x,
    output logic signed [23:0] o_ray_y,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import lud_pkg::*;

    logic [31:0] r_fx_recip, r_fy_recip;
    logic [15:0] r_cx, r_cy;
    logic [63:0] r_left_k, r_right_k;
    logic [2:0]  reg_idx;
    logic        en;

    logic  v   [ITERATIONS+1];
    t_item itm [ITERATIONS+1];

    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx_recip <= FX_RECIP_RST;
            r_fy_recip <= FY_RECIP_RST;
            r_cx       <= CX_RST;
            r_cy       <= CY_RST;
            r_left_k   <= '0;
            r_right_k  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FX_RECIP: r_fx_recip <= pwdata[31:0];
                REG_FY_RECIP: r_fy_recip <= pwdata[31:0];
                REG_CX:       r_cx       <= pwdata[15:0];
                REG_CY:       r_cy       <= pwdata[15:0];
                REG_LEFT_K:   r_left_k   <= pwdata;
                REG_RIGHT_K:  r_right_k  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FX_RECIP: prdata = {32'd0, r_fx_recip};
            REG_FY_RECIP: prdata = {32'd0, r_fy_recip};
            REG_CX:       prdata = {48'd0, r_cx};
            REG_CY:       prdata = {48'd0, r_cy};
            REG_LEFT_K:   prdata = r_left_k;
            REG_RIGHT_K:  prdata = r_right_k;
            default:      prdata = '0;
        endcase
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    lud_norm u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid),
        .i_u        (i_pixel_u),
        .i_v        (i_pixel_v),
        .i_left     (i_camera_left),
        .i_fx_recip (r_fx_recip),
        .i_fy_recip (r_fy_recip),
        .i_cx       (r_cx),
        .i_cy       (r_cy),
        .i_left_k   (r_left_k),
        .i_right_k  (r_right_k),
        .o_valid    (v[0]),
        .o_item     (itm[0])
    );

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
        lud_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_item  (itm[g]),
            .o_valid (v[g+1]),
            .o_item  (itm[g+1])
        );
    end

    assign o_out_valid = v[ITERATIONS];
    assign o_ray_x     = itm[ITERATIONS].x;
    assign o_ray_y     = itm[ITERATIONS].y;
    assign o_saturated = itm[ITERATIONS].s;

endmodule

FILE: sv/lud_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lud_checker
// Port-level checks for the lens undistortion unit.
// ----------------------------------------------------------------------------
module lud_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [23:0] o_ray_x,
    input logic signed [23:0] o_ray_y,
    input logic               o_saturated,
    input logic               pready
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid right after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output side");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ray_x)
            && $stable(o_ray_y) && $stable(o_saturated))
        else $error("stalled output beat changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind iterative_lens_undistortion_unit lud_checker u_lud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ray_x     (o_ray_x),
    .o_ray_y     (o_ray_y),
    .o_saturated (o_saturated),
    .pready      (pready)
);

FILE: test/lens_undistortion_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_undistortion_checker
// Watches the pixel, ray and register channels and checks every ray beat.
// It keeps its own copy of the registers from the write traffic it sees.
// Each accepted pixel beat is turned into an expected ray by a fixed-point
// undistortion model. Ray beats are compared in order against that model.
// ----------------------------------------------------------------------------
module lens_undistortion_checker #(
    parameter int ITERATIONS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_pixel_u,
    input  logic [15:0]        i_pixel_v,
    input  logic               i_camera_left,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [23:0] i_ray_x,
    input  logic signed [23:0] i_ray_y,
    input  logic               i_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_rays_checked,
    output int                 o_rays_clipped
);
    import lud_pkg::*;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic               s;
    } t_ray;

    logic [31:0] rfx, rfy;
    logic [15:0] cx, cy;
    logic [63:0] left_k, right_k;
    t_ray        ray_queue[$];
    bit          clip_flag;

    function automatic longint round_down(longint v, int n);
        longint half;
        half = 64'sd1 << (n - 1);
        return (v + half) >>> n;
    endfunction

    function automatic longint limit(longint v, int bits);
        longint top;
        top = (64'sd1 << (bits - 1)) - 1;
        if (v > top) begin
            clip_flag = 1'b1;
            return top;
        end
        if (v < -top - 1) begin
            clip_flag = 1'b1;
            return -top - 1;
        end
        return v;
    endfunction

    function automatic longint pmul(longint a, longint b, int n);
        return limit(round_down(a * b, n), WIDE_W);
    endfunction

    function automatic longint wsum(longint a, longint b);
        return limit(a + b, WIDE_W);
    endfunction

    function automatic t_ray undistort(logic [15:0] u, logic [15:0] v, logic left);
        logic [63:0] kreg;
        longint      k[4];
        longint      xd, yd, x, y, x2, y2, xy, r2, r4, rad, tx, ty;
        t_ray        r;
        clip_flag = 1'b0;
        kreg = left ? left_k : right_k;
        for (int i = 0; i < 4; i++) k[i] = longint'($signed(kreg[16*i +: 16]));
        xd = limit(round_down((longint'(u) - longint'(cx)) * longint'(rfx), 16), PT_W);
        yd = limit(round_down((longint'(v) - longint'(cy)) * longint'(rfy), 16), PT_W);
        x = xd;
        y = yd;
        for (int it = 0; it < ITERATIONS; it++) begin
            x2  = pmul(x, x, 20);
            y2  = pmul(y, y, 20);
            xy  = pmul(x, y, 20);
            r2  = wsum(x2, y2);
            r4  = pmul(r2, r2, 20);
            rad = wsum(pmul(k[0], r2, 12), pmul(k[1], r4, 12));
            tx = pmul(x, rad, 20);
            tx = wsum(tx, pmul(2 * k[2], xy, 12));
            tx = wsum(tx, pmul(k[3], wsum(r2, 2 * x2), 12));
            ty = pmul(y, rad, 20);
            ty = wsum(ty, pmul(2 * k[3], xy, 12));
            ty = wsum(ty, pmul(k[2], wsum(r2, 2 * y2), 12));
            x = limit(xd - tx, PT_W);
            y = limit(yd - ty, PT_W);
        end
        r.x = x[23:0];
        r.y = y[23:0];
        r.s = clip_flag;
        return r;
    endfunction

    assign o_pending = ray_queue.size();

    always @(posedge i_clk) begin
        t_ray want;
        if (!i_rst_n) begin
            rfx <= FX_RECIP_RST;
            rfy <= FY_RECIP_RST;
            cx <= CX_RST;
            cy <= CY_RST;
            left_k <= '0;
            right_k <= '0;
            ray_queue.delete();
            o_fail_count <= 0;
            o_rays_checked <= 0;
            o_rays_clipped <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                ray_queue.insert(ray_queue.size(),
                                 undistort(i_pixel_u, i_pixel_v, i_camera_left));
            end
            if (i_out_valid && i_out_ready) begin
                o_rays_checked <= o_rays_checked + 1;
                o_rays_clipped <= o_rays_clipped + int'(i_saturated);
                if (ray_queue.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("error: ray beat with nothing expected x=%0d y=%0d",
                                 i_ray_x, i_ray_y);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = ray_queue.pop_front();
                    if (want.x !== i_ray_x || want.y !== i_ray_y
                            || want.s !== i_saturated) begin
                        if (o_fail_count < 10) begin
                            $display({"error: ray mismatch expected x=%0d y=%0d sat=%0b,",
                                      " got x=%0d y=%0d sat=%0b"},
                                     want.x, want.y, want.s, i_ray_x, i_ray_y,
                                     i_saturated);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_FX_RECIP: rfx <= pwdata[31:0];
                    REG_FY_RECIP: rfy <= pwdata[31:0];
                    REG_CX:       cx <= pwdata[15:0];
                    REG_CY:       cy <= pwdata[15:0];
                    REG_LEFT_K:   left_k <= pwdata;
                    REG_RIGHT_K:  right_k <= pwdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the iterative lens undistortion unit.
// Several register settings are loaded in turn, each followed by random and,
// for the first three, directed pixel beats in bursts; rays stall at random.
// One phase holds the ray side off long enough to back up the pipeline.
// ----------------------------------------------------------------------------
module testbench;
    import lud_pkg::*;

    localparam int ITERATIONS = 8;
    localparam int LATENCY = 1 + STAGES_PER_ITER * ITERATIONS;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [15:0]        i_pixel_u = '0;
    logic [15:0]        i_pixel_v = '0;
    logic               i_camera_left = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [23:0] o_ray_x, o_ray_y;
    logic               o_saturated;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;

    int fail_count, pending, rays_checked, rays_clipped;
    int burst_left = 0;
    int hold_request = 0;
    int idle_cycles = 0;
    int pixels_sent = 0;

    always #10 i_clk = ~i_clk;

    iterative_lens_undistortion_unit #(.ITERATIONS(ITERATIONS)) dut (.*);

    lens_undistortion_checker #(.ITERATIONS(ITERATIONS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_pixel_u(i_pixel_u), .i_pixel_v(i_pixel_v), .i_camera_left(i_camera_left),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_ray_x(o_ray_x), .i_ray_y(o_ray_y), .i_saturated(o_saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_rays_checked(rays_checked), .o_rays_clipped(rays_clipped)
    );

    // The ray side stalls on a pattern that changes mode now and then.
    always @(negedge i_clk) begin
        int mode;
        if (hold_request > 0) begin
            i_out_ready = 1'b0;
            hold_request = hold_request - 1;
        end else begin
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: i_out_ready = 1'b1;
                1: i_out_ready = ($urandom_range(0, 3) != 0);
                default: i_out_ready = ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("error: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {index, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [15:0] u, logic [15:0] v, logic left, bit gaps);
        if (gaps && burst_left == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0) burst_left = burst_left - 1;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_pixel_u = u;
        i_pixel_v = v;
        i_camera_left = left;
        do @(posedge i_clk); while (!o_in_ready);
        pixels_sent++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic random_pixels(int count, bit gaps);
        logic [15:0] u, v;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 6) begin
                u = 16'(int'(u_checker.cx) + $signed($urandom_range(0, 8191)) - 4096);
                v = 16'(int'(u_checker.cy) + $signed($urandom_range(0, 8191)) - 4096);
            end else begin
                u = 16'($urandom_range(0, 65535));
                v = 16'($urandom_range(0, 65535));
            end
            send_pixel(u, v, 1'($urandom_range(0, 1)), gaps);
        end
    endtask

    task automatic corner_pixels();
        send_pixel(16'h0000, 16'h0000, 1'b1, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_pixel(16'h0000, 16'hFFFF, 1'b1, 1'b0);
        send_pixel(16'hFFFF, 16'h0000, 1'b0, 1'b0);
        send_pixel(16'd7680, 16'd5760, 1'b1, 1'b0);
        send_pixel(16'h5555, 16'hAAAA, 1'b0, 1'b0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers, no distortion.
        corner_pixels();
        random_pixels(90, 1'b1);
        idle_input();
        drain();

        // A typical lens on the left, a milder one on the right.
        write_reg(REG_LEFT_K, {16'shFFF1, 16'sd20, 16'sd410, 16'shFB33});
        write_reg(REG_RIGHT_K, {16'sd12, 16'shFFF6, 16'sd100, 16'shFE00});
        write_reg(REG_FX_RECIP, 64'(32'd6000000));
        write_reg(REG_FY_RECIP, 64'(32'd5500000));
        corner_pixels();
        random_pixels(100, 1'b1);
        // Back the pipeline up while pixels keep coming.
        hold_request = 300;
        random_pixels(100, 1'b0);
        idle_input();
        drain();

        // Extremes of every register; an out-of-range index is ignored.
        write_reg(REG_FX_RECIP, 64'(32'hFFFFFFFF));
        write_reg(REG_FY_RECIP, 64'(32'h00000000));
        write_reg(REG_CX, 64'(16'h0000));
        write_reg(REG_CY, 64'(16'hFFFF));
        write_reg(REG_LEFT_K, {4{16'h7FFF}});
        write_reg(REG_RIGHT_K, {4{16'h8000}});
        write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        corner_pixels();
        random_pixels(40, 1'b1);
        idle_input();
        drain();

        // Random registers for four settings.
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_FX_RECIP,
                      64'($urandom_range(0, 32'h00FFFFFF) >> $urandom_range(0, 8)));
            write_reg(REG_FY_RECIP, 64'($urandom));
            write_reg(REG_CX, 64'($urandom_range(0, 65535)));
            write_reg(REG_CY, 64'($urandom_range(0, 65535)));
            write_reg(REG_LEFT_K, {$urandom, $urandom} >> ($urandom_range(0, 3) * 4));
            write_reg(REG_RIGHT_K, {$urandom, $urandom});
            random_pixels(55, 1'b1);
            idle_input();
            drain();
        end

        // Put the registers back to their reset values.
        write_reg(REG_FX_RECIP, 64'(FX_RECIP_RST));
        write_reg(REG_FY_RECIP, 64'(FY_RECIP_RST));
        write_reg(REG_CX, 64'(CX_RST));
        write_reg(REG_CY, 64'(CY_RST));
        write_reg(REG_LEFT_K, '0);
        write_reg(REG_RIGHT_K, '0);
        random_pixels(20, 1'b1);
        idle_input();
        drain();

        $display("Sent %0d pixel beats over eight register settings.", pixels_sent);
        $display("Checked %0d ray beats, %0d of them clipped.", rays_checked, rays_clipped);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/lud_pkg.sv
sv/lud_norm.sv
sv/lud_iter.sv
sv/iterative_lens_undistortion_unit.sv
sv/lud_checker.sv
test/lens_undistortion_checker.sv
test/testbench.sv
